@@ hw/rtl/binary_morphology_filter_core_macros.svh @@
// Assertion macros shared by the morphology filter checkers.
`ifndef BINARY_MORPHOLOGY_FILTER_CORE_MACROS_SVH
`define BINARY_MORPHOLOGY_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BMF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bmf_pkg.sv @@
// Shared constants, types and register codes of the morphology filter.
package bmf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_KERNEL = 7;
  localparam int unsigned MIN_DIM    = 8;
  localparam int unsigned MIN_KERNEL = 2;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned KSZ_W      = 3;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROWPOS_W   = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned STORE_ROWS = MAX_KERNEL - 1;

  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned OUT_DW     = 32;
  localparam int unsigned OUT_PAD_W  = OUT_DW - PIX_W - 2 * COORD_W;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_KERNEL = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [KSZ_W-1:0] KERNEL_RST = 3'd3;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

  typedef logic [PIX_W-1:0] pix_t;
  // Column of pixels, entry 0 is the newest row
  typedef logic [MAX_KERNEL-1:0][PIX_W-1:0] colvec_t;
  typedef logic [STORE_ROWS-1:0][PIX_W-1:0] storevec_t;

  // Per-column window control handed from the input stage to the window
  typedef struct packed {
    logic             col_zero;    // newest column belongs to the next row
    logic             top_invalid; // newest row lies below the image
    logic             filter;      // center inside the processed region
    logic             erode;
    logic [KSZ_W-1:0] ksize;
  } step_t;

endpackage

@@ hw/rtl/binary_morphology_filter_core.sv @@
// Top level of the streaming binary morphology filter (dilate / erode).
//
// Usage:
//  - Input stream: one item per pixel in raster order (tuser = 0) or a flush
//    item (tuser = 1). A pixel item past W+1 pixels of the image yields the
//    result W+1 positions back; after the last pixel, W+1 flush items drain
//    the tail. Extra flushes yield nothing. A pixel after a complete image
//    starts the next image and drops its undrained results.
//  - Output stream: filtered pixel with its row/column, tlast on the final
//    pixel of the image.
//  - APB registers: mode, kernel size, width, height; any write restarts the
//    image. Write only while no item is in flight.
//  - Result path: an item is registered in the input stage, then its result
//    goes to the result register, where it is valid.
//  - Throughput: one item per cycle while the result stream is not stalled,
//    set by the single read and single write of the line store per column.
//  - Reset: registers return to 3x3 dilate at 640x480, counters clear. The
//    line store holds garbage until written; no result reads it earlier.
//  - Stall: the result register holds while tready is low; the input stage
//    still takes one more item before tready drops.
module binary_morphology_filter_core import bmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic              s_axis_tuser,   // [0] op: 0 pixel, 1 flush
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // [7:0] pixel_out, [17:8] out_row,
                                            // [27:18] out_col, [31:28] zero
  output logic              m_axis_tlast,   // last
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- config
  logic             mode_q;
  logic [KSZ_W-1:0] kernel_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      kernel_q <= KERNEL_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:   mode_q   <= pwdata[0];
        REG_KERNEL: kernel_q <= pwdata[KSZ_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:   prdata = APB_DW'(mode_q);
      REG_KERNEL: prdata = APB_DW'(kernel_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // Effective (saturated) geometry
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] h_eff_p1;
  logic [KSZ_W-1:0] k_eff;
  logic [KSZ_W-1:0] lo;

  always_comb begin
    if (width_q < DIM_W'(MIN_DIM))         w_eff = DIM_W'(MIN_DIM);
    else if (width_q > DIM_W'(MAX_WIDTH))  w_eff = DIM_W'(MAX_WIDTH);
    else                                   w_eff = width_q;
    if (height_q < DIM_W'(MIN_DIM))        h_eff = DIM_W'(MIN_DIM);
    else if (height_q > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else                                   h_eff = height_q;
    if (kernel_q < KSZ_W'(MIN_KERNEL))     k_eff = KSZ_W'(MIN_KERNEL);
    else if (kernel_q > KSZ_W'(MAX_KERNEL)) k_eff = KSZ_W'(MAX_KERNEL);
    else                                   k_eff = kernel_q;
  end

  assign h_eff_p1 = DIM_W'(h_eff + 1'b1);
  assign lo       = KSZ_W'(k_eff - KSZ_W'(MIN_KERNEL));

  // ---------------------------------------------------------- input stage
  // pos_* is the raster position of the next column step. Past the image it
  // keeps counting into the rows below so flushes reuse the same window.
  logic [ROWPOS_W-1:0] pos_row_q, pos_row_d;
  logic [COL_W-1:0]    pos_col_q, pos_col_d;
  logic [COORD_W-1:0]  orow_q, orow_d;
  logic [COORD_W-1:0]  ocol_q, ocol_d;

  logic                s1_v_q;
  logic                s1_adv;
  logic                out_v_q;
  logic                accept_in;
  logic                is_flush;
  logic                img_full;
  logic                img_done;
  logic                step;
  logic                emit;
  logic [ROWPOS_W-1:0] p_row;
  logic [COL_W-1:0]    p_col;
  logic [DIM_W-1:0]    col_next;
  logic                col_wrap;
  logic [DIM_W-1:0]    ocol_next;
  logic                col_zero;
  logic                top_invalid;
  logic                filt;
  logic                is_last;
  step_t               ctrl_in;

  assign s1_adv        = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign is_flush      = s_axis_tuser;

  assign img_full = DIM_W'(pos_row_q) >= h_eff;
  assign img_done = (DIM_W'(pos_row_q) == h_eff_p1) && (pos_col_q != '0);

  always_comb begin
    // A pixel after a full image restarts at the origin
    p_row = (!is_flush && img_full) ? '0 : pos_row_q;
    p_col = (!is_flush && img_full) ? '0 : pos_col_q;
    step  = !is_flush || (img_full && !img_done);
    if (is_flush) begin
      emit = step;
    end else begin
      emit = !img_full && ((pos_row_q >= ROWPOS_W'(2)) ||
             ((pos_row_q == ROWPOS_W'(1)) && (pos_col_q != '0)));
    end
    col_next  = DIM_W'(p_col) + 1'b1;
    col_wrap  = (col_next == w_eff);
    ocol_next = DIM_W'(ocol_q) + 1'b1;
    col_zero  = (p_col == '0);
    top_invalid = col_zero ? (DIM_W'(p_row) == h_eff_p1) : (DIM_W'(p_row) == h_eff);
    filt = (orow_q >= COORD_W'(lo)) && ((DIM_W'(orow_q) + DIM_W'(lo)) < h_eff) &&
           (ocol_q >= COORD_W'(lo)) && ((DIM_W'(ocol_q) + DIM_W'(lo)) < w_eff);
    is_last = (DIM_W'(orow_q) == DIM_W'(h_eff - 1'b1)) &&
              (DIM_W'(ocol_q) == DIM_W'(w_eff - 1'b1));

    ctrl_in.col_zero    = col_zero;
    ctrl_in.top_invalid = top_invalid;
    ctrl_in.filter      = filt;
    ctrl_in.erode       = mode_q;
    ctrl_in.ksize       = k_eff;

    pos_row_d = pos_row_q;
    pos_col_d = pos_col_q;
    orow_d    = orow_q;
    ocol_d    = ocol_q;
    if (cfg_wr) begin
      pos_row_d = '0;
      pos_col_d = '0;
      orow_d    = '0;
      ocol_d    = '0;
    end else if (accept_in) begin
      if (step) begin
        pos_col_d = col_wrap ? '0 : col_next[COL_W-1:0];
        pos_row_d = col_wrap ? ROWPOS_W'(p_row + 1'b1) : p_row;
      end
      if (!is_flush && img_full) begin
        orow_d = '0;
        ocol_d = '0;
      end else if (emit) begin
        if (ocol_next == w_eff) begin
          ocol_d = '0;
          orow_d = COORD_W'(orow_q + 1'b1);
        end else begin
          ocol_d = ocol_next[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q <= '0;
      pos_col_q <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
    end else begin
      pos_row_q <= pos_row_d;
      pos_col_q <= pos_col_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
    end
  end

  // ------------------------------------------------------------- stage 1
  logic               s1_step_q;
  logic               s1_emit_q;
  pix_t               s1_pix_q;
  logic [COL_W-1:0]   s1_col_q;
  step_t              s1_ctrl_q;
  logic [COORD_W-1:0] s1_row_q;
  logic [COORD_W-1:0] s1_ocol_q;
  logic               s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= accept_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_step_q <= step;
      s1_emit_q <= emit;
      s1_pix_q  <= s_axis_tdata;
      s1_col_q  <= p_col;
      s1_ctrl_q <= ctrl_in;
      s1_row_q  <= orow_q;
      s1_ocol_q <= ocol_q;
      s1_last_q <= is_last;
    end
  end

  storevec_t rd_data;
  storevec_t wr_data;
  colvec_t   cur_col;
  logic      col_shift;
  pix_t      win_pix;

  always_comb begin
    cur_col[0] = s1_pix_q;
    wr_data[0] = s1_pix_q;
    for (int j = 1; j < MAX_KERNEL; j++) begin
      cur_col[j] = rd_data[j-1];
    end
    for (int j = 1; j < STORE_ROWS; j++) begin
      wr_data[j] = rd_data[j-1];
    end
  end

  assign col_shift = s1_adv && s1_step_q;

  bmf_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept_in),
    .rd_addr_i (p_col),
    .rd_data_o (rd_data),
    .wr_en_i   (col_shift),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data)
  );

  bmf_window u_window (
    .clk_i   (clk_i),
    .shift_i (col_shift),
    .cur_i   (cur_col),
    .ctrl_i  (s1_ctrl_q),
    .pixel_o (win_pix)
  );

  // -------------------------------------------------------- result register
  pix_t               out_pix_q;
  logic [COORD_W-1:0] out_row_q;
  logic [COORD_W-1:0] out_col_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= s1_emit_q;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_pix_q  <= win_pix;
      out_row_q  <= s1_row_q;
      out_col_q  <= s1_ocol_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_q, out_row_q, out_pix_q};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/bmf_line_buf.sv @@
// Line store: one word per column holding the previous rows of that column.
module bmf_line_buf import bmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  output storevec_t        rd_data_o,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  storevec_t        wr_data_i
);

  storevec_t mem_q [MAX_WIDTH];
  storevec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while the consuming stage is stalled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/bmf_window.sv @@
// Window column shift register and square-window match reduction.
module bmf_window import bmf_pkg::*; (
  input  logic    clk_i,
  input  logic    shift_i,
  input  colvec_t cur_i,
  input  step_t   ctrl_i,
  output pix_t    pixel_o
);

  // win_q[0] is the column just left of cur_i
  colvec_t win_q [MAX_KERNEL-1];

  pix_t match_pix;
  pix_t pv;
  logic hit;
  logic use_px;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q[0] <= cur_i;
      for (int d = 1; d < MAX_KERNEL - 1; d++) begin
        win_q[d] <= win_q[d-1];
      end
    end
  end

  always_comb begin
    match_pix = ctrl_i.erode ? PIX_MIN : PIX_MAX;
    hit       = 1'b0;
    pv        = '0;
    use_px    = 1'b0;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
        pv     = (d == 0) ? cur_i[j] : win_q[(d == 0) ? 0 : d - 1][j];
        use_px = (d < int'(ctrl_i.ksize)) && (j < int'(ctrl_i.ksize)) &&
                 !((d == 0) && ctrl_i.col_zero) && !((j == 0) && ctrl_i.top_invalid);
        if (use_px && (pv == match_pix)) begin
          hit = 1'b1;
        end
      end
    end
  end

  // Pass-through pixel is one row up in the previous column
  assign pixel_o = ctrl_i.filter ? (hit ? match_pix : ~match_pix) : win_q[0][1];

endmodule

@@ hw/rtl/bmf_checker.sv @@
// Port-level checker for the morphology filter, bound to the top level.
`include "binary_morphology_filter_core_macros.svh"

module bmf_checker import bmf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // Stalled result must hold
  `BMF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result item changed while stalled")

  // With the result register empty the input side can always take an item
  `BMF_ASSERT_SAME(a_in_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled with empty result register")

  // Register read-back after a write to the same address
  `BMF_ASSERT_NEXT(a_kernel_rb, clk_i, rst_ni, psel && penable && pwrite && pready && (paddr == {REG_KERNEL, 2'b00}), (paddr != $past(paddr)) || (prdata[2:0] == $past(pwdata[2:0])), "kernel size read-back mismatch")

  `BMF_ASSERT_NEXT(a_width_rb, clk_i, rst_ni, psel && penable && pwrite && pready && (paddr == {REG_WIDTH, 2'b00}), (paddr != $past(paddr)) || (prdata[10:0] == $past(pwdata[10:0])), "image width read-back mismatch")

endmodule

bind binary_morphology_filter_core bmf_checker u_bmf_checker (.*);

@@ tb/binary_morphology_filter_core_test.sv @@
// Self-checking testbench for the streaming binary morphology filter core.
module binary_morphology_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmf_pkg::*;

  // Item kinds carried on tuser of the input stream
  localparam bit OP_PIXEL = 1'b0;
  localparam bit OP_FLUSH = 1'b1;
  // Mode register values
  localparam bit MODE_DILATE = 1'b0;
  localparam bit MODE_ERODE  = 1'b1;

  localparam int unsigned TOTAL_ITEMS  = 750;
  localparam int unsigned HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One filtered pixel as it leaves the block
  typedef struct packed {
    pix_t               pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } morph_px_t;

  // Mirror of the filter: register copies, line rows, raster counters and the
  // queue of pixels the block still owes us.
  class morph_frame_model;
    bit               erode;
    bit [KSZ_W-1:0]   ksize;
    bit [DIM_W-1:0]   width;
    bit [DIM_W-1:0]   height;
    bit [PIX_W-1:0]   rows [MAX_KERNEL*MAX_WIDTH];
    int unsigned      row_in;
    int unsigned      col_in;
    int unsigned      next_out;
    bit               image_full;
    morph_px_t        pending[$];
    int unsigned      mismatches;

    function new();
      erode      = MODE_DILATE;
      ksize      = KERNEL_RST;
      width      = WIDTH_RST;
      height     = HEIGHT_RST;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      row_in     = 0;
      col_in     = 0;
      next_out   = 0;
      image_full = 1'b0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_w();
      return clamp(width, MIN_DIM, MAX_WIDTH);
    endfunction

    function int unsigned frame_h();
      return clamp(height, MIN_DIM, MAX_HEIGHT);
    endfunction

    function int unsigned window_k();
      return clamp(ksize, MIN_KERNEL, MAX_KERNEL);
    endfunction

    function int unsigned slot(int unsigned r, int unsigned c);
      return (r % MAX_KERNEL) * MAX_WIDTH + c;
    endfunction

    // Any register write also starts a fresh image
    function void set_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
      case (idx)
        REG_MODE:   erode  = val[0];
        REG_KERNEL: ksize  = val[KSZ_W-1:0];
        REG_WIDTH:  width  = val[DIM_W-1:0];
        REG_HEIGHT: height = val[DIM_W-1:0];
      endcase
      restart();
    endfunction

    // Window covers rows r-(k-2)..r+1 and columns c-(k-2)..c+1
    function void filter_pixel(int unsigned e);
      int unsigned w, h, k, r, c, lo, rr, cc, x, y;
      pix_t        hit, val;
      morph_px_t   px;
      w   = frame_w();
      h   = frame_h();
      k   = window_k();
      r   = e / w;
      c   = e % w;
      lo  = k - 2;
      hit = erode ? PIX_MIN : PIX_MAX;
      if (r >= lo && r + lo < h && c >= lo && c + lo < w) begin
        val = ~hit;
        for (x = 0; x < k; x++) begin
          rr = r - lo + x;
          if (rr < h) begin
            for (y = 0; y < k; y++) begin
              cc = c - lo + y;
              if (cc < w && rows[slot(rr, cc)] == hit) val = hit;
            end
          end
        end
      end else begin
        val = rows[slot(r, c)];    // border pixel passes through
      end
      px.pix  = val;
      px.row  = COORD_W'(r);
      px.col  = COORD_W'(c);
      px.last = (e == w * h - 1);
      pending = {pending, px};
    endfunction

    // Called for every item accepted on the input stream
    function void take_item(bit kind, pix_t pix);
      int unsigned w, h, n;
      w = frame_w();
      h = frame_h();
      if (kind == OP_FLUSH) begin
        // flush drains only once the whole image is in
        if (image_full && next_out < w * h) begin
          filter_pixel(next_out);
          next_out++;
        end
        return;
      end
      if (image_full) restart();    // new image drops undrained pixels
      if (col_in >= w) col_in = 0;
      if (row_in >= h) row_in = 0;
      rows[slot(row_in, col_in)] = pix;
      n = row_in * w + col_in;
      col_in++;
      if (col_in == w) begin
        col_in = 0;
        row_in++;
        if (row_in == h) begin
          row_in     = 0;
          image_full = 1'b1;
        end
      end
      if (n >= w + 1) begin
        filter_pixel(next_out);
        next_out++;
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch %0d: %s", mismatches, what);
    endtask

    task match_pixel(pix_t pix, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                     logic last);
      morph_px_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected pixel %0d at (%0d,%0d)", pix, row, col));
        return;
      end
      want = pending.pop_front();
      if (pix !== want.pix)
        report($sformatf("pixel at (%0d,%0d): got %0d, want %0d",
                         want.row, want.col, pix, want.pix));
      if (row !== want.row)
        report($sformatf("row: got %0d, want %0d", row, want.row));
      if (col !== want.col)
        report($sformatf("col at row %0d: got %0d, want %0d", want.row, col, want.col));
      if (last !== want.last)
        report($sformatf("last at (%0d,%0d): got %0b, want %0b",
                         want.row, want.col, last, want.last));
    endtask
  endclass

  // Clock, reset and block inputs, all known from time zero
  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              s_tvalid = 1'b0;
  logic [PIX_W-1:0]  s_tdata  = '0;
  logic              s_tuser  = OP_PIXEL;
  logic              m_tready = 1'b0;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [APB_AW-1:0] paddr    = '0;
  logic [APB_DW-1:0] pwdata   = '0;

  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  morph_frame_model  model;
  bit                idle_en      = 1'b1;  // random gaps on both streams
  int unsigned       stall_asks   = 0;     // written by stimulus only
  int unsigned       stall_served = 0;     // written by the receiver only
  int unsigned       items_sent   = 0;
  int unsigned       cycle_count  = 0;

  binary_morphology_filter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: the run never gets near this unless the block hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block fills up and has to drop s_axis_tready.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_asks != stall_served) begin
        stall_served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_tready <= !(idle_en && $urandom_range(99) < 24);
    end
  end

  // Output check at each accepting edge.
  // tdata: [7:0] pixel_out, [17:8] out_row, [27:18] out_col
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready)
      model.match_pixel(m_axis_tdata[PIX_W-1:0],
                        m_axis_tdata[PIX_W +: COORD_W],
                        m_axis_tdata[PIX_W+COORD_W +: COORD_W],
                        m_axis_tlast);
  end

  // Offer one item, starting at a falling edge; returns at the falling edge
  // after it was taken. Random gaps go in front of the item.
  task automatic push_item(bit kind, pix_t pix);
    while (idle_en && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    model.take_item(kind, pix);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Register write: setup phase, access phase, then a quiet phase with psel low
  task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(bit mode, int unsigned k, int unsigned w, int unsigned h);
    apb_write(REG_MODE, APB_DW'(mode));
    apb_write(REG_KERNEL, APB_DW'(k));
    apb_write(REG_WIDTH, APB_DW'(w));
    apb_write(REG_HEIGHT, APB_DW'(h));
  endtask

  // Stop offering, wait for every owed pixel, then let trailing flushes die out
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (model.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Mostly binary images; a few odd gray values that match neither rule
  function automatic pix_t draw_pixel(int unsigned ones_pct);
    if ($urandom_range(99) < 8) return pix_t'($urandom_range(255));
    return ($urandom_range(99) < ones_pct) ? PIX_MAX : PIX_MIN;
  endfunction

  // Image side: mostly small, some below the minimum (clamped), a few wider
  function automatic int unsigned draw_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(0, 7);
    if (roll < 15) return $urandom_range(17, 24);
    return $urandom_range(8, 14);
  endfunction

  task automatic send_pixels(int unsigned count, int unsigned ones_pct);
    repeat (count) push_item(OP_PIXEL, draw_pixel(ones_pct));
  endtask

  task automatic send_flushes(int unsigned count);
    repeat (count) push_item(OP_FLUSH, pix_t'($urandom_range(255)));
  endtask

  initial begin
    pix_t        seed_pix[$];
    int unsigned phase, kind, area, lag, dens;

    model = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: flush with nothing pending, then a 2x2 erode on an 8x8 image
    // (width 0 and height 5 clamp up to 8, kernel 1 clamps up to 2) fed with
    // extreme and odd pixel values; an early flush sits in the middle.
    push_item(OP_FLUSH, PIX_MAX);
    settle();
    configure(MODE_ERODE, 1, 0, 5);
    seed_pix = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'hFF,
                 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h40};
    foreach (seed_pix[i]) begin
      push_item(OP_PIXEL, seed_pix[i]);
      if (i == 4) push_item(OP_FLUSH, PIX_MIN);
    end
    settle();

    // Largest sizes: an out-of-range height clamps to 1024 on 8-pixel rows,
    // only the first rows are sent; an out-of-range width clamps to 1024 and
    // too few pixels arrive for any result.
    configure(MODE_ERODE, 3, 8, 2047);
    send_pixels(60, 90);
    settle();
    configure(MODE_DILATE, 0, 2047, 8);
    send_pixels(24, 20);
    settle();

    // Random phases: fresh settings, then one or two images each
    phase = 0;
    while (phase < 3 || items_sent < TOTAL_ITEMS) begin
      settle();
      idle_en = !(phase == 2 || phase == 3);   // a stretch with no gaps at all
      configure(1'($urandom_range(1)),
                (phase == 0) ? 7 : (phase == 1) ? 2 : $urandom_range(0, 7),
                (phase == 0) ? 16 : draw_dim(),
                draw_dim());
      if (phase == 1) stall_asks++;
      area = model.frame_w() * model.frame_h();
      lag  = model.frame_w() + 1;
      repeat ($urandom_range(1, 2)) begin
        kind = $urandom_range(9);
        dens = $urandom_range(10, 90);
        if (kind == 0) begin
          // partial image, flushes arrive too early to yield anything
          send_pixels($urandom_range(1, area - 1), dens);
          send_flushes($urandom_range(0, 2));
        end else if (kind == 1) begin
          // full image, tail left undrained for the next image to drop
          send_pixels(area, dens);
          send_flushes($urandom_range(0, lag - 1));
        end else begin
          // full image, full drain, maybe flushes past the end
          send_pixels(area, dens);
          send_flushes(lag + $urandom_range(0, 2));
        end
      end
      phase++;
    end

    settle();
    if (model.mismatches == 0 && model.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ binary_morphology_filter_core.f @@
+incdir+hw/rtl
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_line_buf.sv
hw/rtl/bmf_window.sv
hw/rtl/binary_morphology_filter_core.sv
hw/rtl/bmf_checker.sv
tb/binary_morphology_filter_core_test.sv
